>>> src/ps2s1_pkg.sv
// shared constants, key kinds and character tables for the set 1 scancode decoder
`default_nettype none
package ps2s1_pkg;

	typedef logic [7:0] code_t;
	typedef logic [3:0] kind_t;
	typedef logic [6:0] char_t;

	localparam int TABLE_LEN = 58;

	localparam code_t CODE_EXT_PREFIX = 8'hE0;
	localparam code_t CODE_LSHIFT     = 8'h2A;
	localparam code_t CODE_RSHIFT     = 8'h36;
	localparam code_t CODE_CTRL       = 8'h1D;
	localparam code_t CODE_ALT        = 8'h38;
	localparam code_t CODE_ENTER      = 8'h1C;
	localparam code_t CODE_BACKSPACE  = 8'h0E;
	localparam code_t CODE_TAB        = 8'h0F;
	localparam code_t CODE_UP         = 8'h48;
	localparam code_t CODE_DOWN       = 8'h50;
	localparam code_t CODE_LEFT       = 8'h4B;
	localparam code_t CODE_RIGHT      = 8'h4D;
	localparam code_t CODE_HOME       = 8'h47;
	localparam code_t CODE_END        = 8'h4F;
	localparam code_t CODE_PGUP       = 8'h49;
	localparam code_t CODE_PGDN       = 8'h51;
	localparam code_t CODE_DELETE     = 8'h53;

	localparam kind_t KIND_CHAR      = 4'd0;
	localparam kind_t KIND_ENTER     = 4'd1;
	localparam kind_t KIND_BACKSPACE = 4'd2;
	localparam kind_t KIND_TAB       = 4'd3;
	localparam kind_t KIND_UP        = 4'd4;
	localparam kind_t KIND_DOWN      = 4'd5;
	localparam kind_t KIND_LEFT      = 4'd6;
	localparam kind_t KIND_RIGHT     = 4'd7;
	localparam kind_t KIND_HOME      = 4'd8;
	localparam kind_t KIND_END       = 4'd9;
	localparam kind_t KIND_PGUP      = 4'd10;
	localparam kind_t KIND_PGDN      = 4'd11;
	localparam kind_t KIND_DELETE    = 4'd12;

	localparam logic [7:0] CHAR_FIRST = 8'd32;
	localparam logic [7:0] CHAR_LAST  = 8'd126;

	// us layout, unshifted
	localparam logic [7:0] PLAIN_CHARS [TABLE_LEN] = '{
		8'h00, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h00,
		8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A, 8'h00,
		"a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60, 8'h00, 8'h5C,
		"z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00, "*", 8'h00, " "
	};

	// us layout, shifted
	localparam logic [7:0] SHIFTED_CHARS [TABLE_LEN] = '{
		8'h00, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h00,
		8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A, 8'h00,
		"A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 8'h00, "|",
		"Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'h00, "*", 8'h00, " "
	};

endpackage
`default_nettype wire

>>> src/ps2_set1_scancode_decoder.sv
// ps/2 set 1 scancode decoder with modifier and extended-prefix tracking
// a transferred scancode is registered in stage 1 and its key event in stage 2 on the outputs
// throughput: one scancode per cycle unless held by a stalled event; a scancode with no event
// retires even while out is stalled; a stalled event only blocks the next scancode with an event
// reset clears the modifier bits, the extended flag and both valid flags
`default_nettype none
module ps2_set1_scancode_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] scan_code,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [3:0]      key_kind,
	output logic [6:0]      ascii_char,
	output logic            shift_held,
	output logic            ctrl_held,
	output logic            alt_held
);

	logic                 valid_s1;
	ps2s1_pkg::code_t     code_s1;
	logic                 valid_s2;
	ps2s1_pkg::kind_t     kind_s2;
	ps2s1_pkg::char_t     char_s2;
	logic                 shift_s2;
	logic                 ctrl_s2;
	logic                 alt_s2;

	logic                 shift_q;
	logic                 ctrl_q;
	logic                 alt_q;
	logic                 ext_q;

	logic                 shift_d;
	logic                 ctrl_d;
	logic                 alt_d;
	logic                 ext_d;
	logic                 has_event;
	ps2s1_pkg::kind_t     kind_d;
	ps2s1_pkg::char_t     char_d;
	logic [7:0]           table_char;
	logic [6:0]           rel_code;

	logic                 out_free;
	logic                 retire_s1;
	logic                 load_s1;

	assign out_free  = !valid_s2 || !out_stall;
	assign retire_s1 = valid_s1 && (!has_event || out_free);
	assign in_stall  = valid_s1 && !retire_s1;
	assign load_s1   = in_valid && !in_stall;

	assign rel_code   = code_s1[6:0];
	assign table_char = shift_q ? ps2s1_pkg::SHIFTED_CHARS[code_s1[5:0]]
	                            : ps2s1_pkg::PLAIN_CHARS[code_s1[5:0]];

	// decode and next modifier state
	always_comb begin
		shift_d   = shift_q;
		ctrl_d    = ctrl_q;
		alt_d     = alt_q;
		ext_d     = ext_q;
		has_event = 1'b0;
		kind_d    = ps2s1_pkg::KIND_CHAR;
		char_d    = '0;
		if (code_s1 == ps2s1_pkg::CODE_EXT_PREFIX) begin
			ext_d = 1'b1;
		end else if (code_s1[7]) begin
			if (rel_code == ps2s1_pkg::CODE_LSHIFT[6:0] ||
			    rel_code == ps2s1_pkg::CODE_RSHIFT[6:0]) begin
				shift_d = 1'b0;
			end
			if (rel_code == ps2s1_pkg::CODE_CTRL[6:0]) begin
				ctrl_d = 1'b0;
			end
			if (rel_code == ps2s1_pkg::CODE_ALT[6:0]) begin
				alt_d = 1'b0;
			end
		end else if (code_s1 == ps2s1_pkg::CODE_LSHIFT ||
		             code_s1 == ps2s1_pkg::CODE_RSHIFT) begin
			shift_d = 1'b1;
		end else if (code_s1 == ps2s1_pkg::CODE_CTRL) begin
			ctrl_d = 1'b1;
		end else if (code_s1 == ps2s1_pkg::CODE_ALT) begin
			alt_d = 1'b1;
		end else if (ext_q) begin
			ext_d     = 1'b0;
			has_event = 1'b1;
			unique case (code_s1)
				ps2s1_pkg::CODE_UP:     kind_d = ps2s1_pkg::KIND_UP;
				ps2s1_pkg::CODE_DOWN:   kind_d = ps2s1_pkg::KIND_DOWN;
				ps2s1_pkg::CODE_LEFT:   kind_d = ps2s1_pkg::KIND_LEFT;
				ps2s1_pkg::CODE_RIGHT:  kind_d = ps2s1_pkg::KIND_RIGHT;
				ps2s1_pkg::CODE_HOME:   kind_d = ps2s1_pkg::KIND_HOME;
				ps2s1_pkg::CODE_END:    kind_d = ps2s1_pkg::KIND_END;
				ps2s1_pkg::CODE_PGUP:   kind_d = ps2s1_pkg::KIND_PGUP;
				ps2s1_pkg::CODE_PGDN:   kind_d = ps2s1_pkg::KIND_PGDN;
				ps2s1_pkg::CODE_DELETE: kind_d = ps2s1_pkg::KIND_DELETE;
				default:                has_event = 1'b0;
			endcase
		end else begin
			has_event = 1'b1;
			unique case (code_s1)
				ps2s1_pkg::CODE_ENTER:     kind_d = ps2s1_pkg::KIND_ENTER;
				ps2s1_pkg::CODE_BACKSPACE: kind_d = ps2s1_pkg::KIND_BACKSPACE;
				ps2s1_pkg::CODE_TAB:       kind_d = ps2s1_pkg::KIND_TAB;
				ps2s1_pkg::CODE_UP:        kind_d = ps2s1_pkg::KIND_UP;
				ps2s1_pkg::CODE_DOWN:      kind_d = ps2s1_pkg::KIND_DOWN;
				ps2s1_pkg::CODE_HOME:      kind_d = ps2s1_pkg::KIND_HOME;
				ps2s1_pkg::CODE_END:       kind_d = ps2s1_pkg::KIND_END;
				ps2s1_pkg::CODE_PGUP:      kind_d = ps2s1_pkg::KIND_PGUP;
				ps2s1_pkg::CODE_PGDN:      kind_d = ps2s1_pkg::KIND_PGDN;
				default: begin
					kind_d = ps2s1_pkg::KIND_CHAR;
					if (code_s1 < 8'(ps2s1_pkg::TABLE_LEN) &&
					    table_char >= ps2s1_pkg::CHAR_FIRST &&
					    table_char <= ps2s1_pkg::CHAR_LAST) begin
						char_d = table_char[6:0];
					end else begin
						has_event = 1'b0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			shift_q  <= 1'b0;
			ctrl_q   <= 1'b0;
			alt_q    <= 1'b0;
			ext_q    <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= 1'b1;
			end else if (retire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (retire_s1 && has_event) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (retire_s1) begin
				shift_q <= shift_d;
				ctrl_q  <= ctrl_d;
				alt_q   <= alt_d;
				ext_q   <= ext_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			code_s1 <= scan_code;
		end
		if (retire_s1 && has_event) begin
			kind_s2  <= kind_d;
			char_s2  <= char_d;
			shift_s2 <= shift_q;
			ctrl_s2  <= ctrl_q;
			alt_s2   <= alt_q;
		end
	end

	assign out_valid  = valid_s2;
	assign key_kind   = kind_s2;
	assign ascii_char = char_s2;
	assign shift_held = shift_s2;
	assign ctrl_held  = ctrl_s2;
	assign alt_held   = alt_s2;

endmodule
`default_nettype wire

>>> src/ps2s1_checker.sv
// port-level checks for the set 1 scancode decoder, bound to the top level
`default_nettype none
module ps2s1_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [3:0] key_kind,
	input wire logic [6:0] ascii_char,
	input wire logic       shift_held,
	input wire logic       ctrl_held,
	input wire logic       alt_held
);

	// a stalled event stays offered
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("event dropped while stalled");

	// a stalled event keeps its payload
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(key_kind) && $stable(ascii_char) &&
		$stable(shift_held) && $stable(ctrl_held) && $stable(alt_held))
		else $error("event payload changed while stalled");

	// only character events carry a character
	a_non_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_kind != ps2s1_pkg::KIND_CHAR |-> ascii_char == 7'd0)
		else $error("non-character event with a character");

	// character events are printable
	a_char_printable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_kind == ps2s1_pkg::KIND_CHAR |->
		ascii_char >= 7'd32 && ascii_char <= 7'd126)
		else $error("character event outside the printable range");

	// the input is held back only by a stalled event
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled event");

endmodule

bind ps2_set1_scancode_decoder ps2s1_checker u_ps2s1_checker (.*);
`default_nettype wire

>>> test/tb_top.sv
// testbench for the ps/2 set 1 scancode decoder, predicting key events per transfer
`default_nettype none
module tb_top;

	typedef struct packed {
		ps2s1_pkg::kind_t kind;
		ps2s1_pkg::char_t ch;
		logic             shift;
		logic             ctrl;
		logic             alt;
	} key_press_t;

	// own copy of the us layout
	localparam logic [7:0] US_LOWER [ps2s1_pkg::TABLE_LEN] = '{
		8'h00, 8'd27, "1", "2", "3", "4", "5", "6", "7", "8", "9", "0", "-", "=", 8'h00,
		8'h09, "q", "w", "e", "r", "t", "y", "u", "i", "o", "p", "[", "]", 8'h0A, 8'h00,
		"a", "s", "d", "f", "g", "h", "j", "k", "l", ";", 8'h27, 8'h60, 8'h00, 8'h5C,
		"z", "x", "c", "v", "b", "n", "m", ",", ".", "/", 8'h00, "*", 8'h00, " "
	};
	localparam logic [7:0] US_UPPER [ps2s1_pkg::TABLE_LEN] = '{
		8'h00, 8'd27, "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "_", "+", 8'h00,
		8'h09, "Q", "W", "E", "R", "T", "Y", "U", "I", "O", "P", "{", "}", 8'h0A, 8'h00,
		"A", "S", "D", "F", "G", "H", "J", "K", "L", ":", 8'h22, "~", 8'h00, "|",
		"Z", "X", "C", "V", "B", "N", "M", "<", ">", "?", 8'h00, "*", 8'h00, " "
	};

	localparam ps2s1_pkg::code_t BREAK_FLAG = 8'h80;
	localparam int               REPORT_MAX = 10;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	ps2s1_pkg::code_t scan_code = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	ps2s1_pkg::kind_t key_kind;
	ps2s1_pkg::char_t ascii_char;
	logic             shift_held;
	logic             ctrl_held;
	logic             alt_held;

	logic shift_q = 1'b0;
	logic ctrl_q = 1'b0;
	logic alt_q = 1'b0;
	logic ext_q = 1'b0;

	key_press_t expected_keys [$];
	int fail_count = 0;
	int codes_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	ps2_set1_scancode_decoder u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.scan_code  (scan_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_kind   (key_kind),
		.ascii_char (ascii_char),
		.shift_held (shift_held),
		.ctrl_held  (ctrl_held),
		.alt_held   (alt_held)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

	task automatic predict_key(input ps2s1_pkg::code_t c);
		key_press_t ev;
		logic hit;
		logic [7:0] ch;
		ps2s1_pkg::code_t rel;
		ev = '0;
		ev.shift = shift_q;
		ev.ctrl = ctrl_q;
		ev.alt = alt_q;
		hit = 1'b0;
		rel = c & ~BREAK_FLAG;
		if (c == ps2s1_pkg::CODE_EXT_PREFIX) begin
			ext_q = 1'b1;
		end else if (c[7]) begin
			if (rel == ps2s1_pkg::CODE_LSHIFT || rel == ps2s1_pkg::CODE_RSHIFT) shift_q = 1'b0;
			if (rel == ps2s1_pkg::CODE_CTRL) ctrl_q = 1'b0;
			if (rel == ps2s1_pkg::CODE_ALT) alt_q = 1'b0;
		end else if (c == ps2s1_pkg::CODE_LSHIFT || c == ps2s1_pkg::CODE_RSHIFT) begin
			shift_q = 1'b1;
		end else if (c == ps2s1_pkg::CODE_CTRL) begin
			ctrl_q = 1'b1;
		end else if (c == ps2s1_pkg::CODE_ALT) begin
			alt_q = 1'b1;
		end else if (ext_q) begin
			ext_q = 1'b0;
			hit = 1'b1;
			case (c)
				ps2s1_pkg::CODE_UP:     ev.kind = ps2s1_pkg::KIND_UP;
				ps2s1_pkg::CODE_DOWN:   ev.kind = ps2s1_pkg::KIND_DOWN;
				ps2s1_pkg::CODE_LEFT:   ev.kind = ps2s1_pkg::KIND_LEFT;
				ps2s1_pkg::CODE_RIGHT:  ev.kind = ps2s1_pkg::KIND_RIGHT;
				ps2s1_pkg::CODE_HOME:   ev.kind = ps2s1_pkg::KIND_HOME;
				ps2s1_pkg::CODE_END:    ev.kind = ps2s1_pkg::KIND_END;
				ps2s1_pkg::CODE_PGUP:   ev.kind = ps2s1_pkg::KIND_PGUP;
				ps2s1_pkg::CODE_PGDN:   ev.kind = ps2s1_pkg::KIND_PGDN;
				ps2s1_pkg::CODE_DELETE: ev.kind = ps2s1_pkg::KIND_DELETE;
				default:                hit = 1'b0;
			endcase
		end else begin
			hit = 1'b1;
			case (c)
				ps2s1_pkg::CODE_ENTER:     ev.kind = ps2s1_pkg::KIND_ENTER;
				ps2s1_pkg::CODE_BACKSPACE: ev.kind = ps2s1_pkg::KIND_BACKSPACE;
				ps2s1_pkg::CODE_TAB:       ev.kind = ps2s1_pkg::KIND_TAB;
				ps2s1_pkg::CODE_UP:        ev.kind = ps2s1_pkg::KIND_UP;
				ps2s1_pkg::CODE_DOWN:      ev.kind = ps2s1_pkg::KIND_DOWN;
				ps2s1_pkg::CODE_HOME:      ev.kind = ps2s1_pkg::KIND_HOME;
				ps2s1_pkg::CODE_END:       ev.kind = ps2s1_pkg::KIND_END;
				ps2s1_pkg::CODE_PGUP:      ev.kind = ps2s1_pkg::KIND_PGUP;
				ps2s1_pkg::CODE_PGDN:      ev.kind = ps2s1_pkg::KIND_PGDN;
				default: begin
					if (int'(c) < ps2s1_pkg::TABLE_LEN) begin
						ch = shift_q ? US_UPPER[c[5:0]] : US_LOWER[c[5:0]];
						ev.kind = ps2s1_pkg::KIND_CHAR;
						ev.ch = ch[6:0];
						hit = (ch >= ps2s1_pkg::CHAR_FIRST) && (ch <= ps2s1_pkg::CHAR_LAST);
					end else begin
						hit = 1'b0;
					end
				end
			endcase
		end
		if (hit) expected_keys.push_back(ev);
	endtask

	// called at a rising edge, returns at the edge of the transfer
	task automatic send_code(input ps2s1_pkg::code_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		scan_code <= c;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_key(c);
		codes_sent++;
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_keys.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic report_fail(input string what, input key_press_t want, input key_press_t got);
		fail_count++;
		if (fail_count <= REPORT_MAX)
			$display("%s: expected kind %0d char %0d mods %b%b%b, %s %0d char %0d mods %b%b%b",
				what, want.kind, want.ch, want.shift, want.ctrl, want.alt,
				"got kind", got.kind, got.ch, got.shift, got.ctrl, got.alt);
	endtask

	always @(posedge clk) begin : key_check
		key_press_t got;
		key_press_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.kind = key_kind;
			got.ch = ascii_char;
			got.shift = shift_held;
			got.ctrl = ctrl_held;
			got.alt = alt_held;
			if (expected_keys.size() == 0) begin
				report_fail("unexpected key event", '0, got);
			end else begin
				want = expected_keys.pop_front();
				if (got !== want) report_fail("key event mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic test_plain_keys();
		send_code(ps2s1_pkg::CODE_ENTER);
		send_code(ps2s1_pkg::CODE_BACKSPACE);
		send_code(ps2s1_pkg::CODE_TAB);
		send_code(ps2s1_pkg::CODE_UP);
		send_code(8'h00);
		send_code(8'h01);
		send_code(8'h39);
		send_code(8'h3A);
		send_code(8'h7F);
	endtask

	task automatic test_modifiers();
		send_code(ps2s1_pkg::CODE_LSHIFT);
		send_code(8'h1E);
		send_code(ps2s1_pkg::CODE_CTRL);
		send_code(ps2s1_pkg::CODE_ALT);
		send_code(8'h02);
		send_code(ps2s1_pkg::CODE_LSHIFT | BREAK_FLAG);
		send_code(ps2s1_pkg::CODE_CTRL | BREAK_FLAG);
		send_code(ps2s1_pkg::CODE_ALT | BREAK_FLAG);
		send_code(8'hFF);
	endtask

	// modifier makes and break codes must not drop a pending prefix
	task automatic test_extended_prefix();
		send_code(ps2s1_pkg::CODE_EXT_PREFIX);
		send_code(ps2s1_pkg::CODE_LEFT);
		send_code(ps2s1_pkg::CODE_EXT_PREFIX);
		send_code(ps2s1_pkg::CODE_RSHIFT);
		send_code(ps2s1_pkg::CODE_RSHIFT | BREAK_FLAG);
		send_code(ps2s1_pkg::CODE_DELETE);
		send_code(ps2s1_pkg::CODE_EXT_PREFIX);
		send_code(8'h10);
		send_code(8'h10);
	endtask

	task automatic test_random_traffic(input int n_codes);
		ps2s1_pkg::code_t plain_keys [9];
		ps2s1_pkg::code_t ext_keys [9];
		ps2s1_pkg::code_t mods [4];
		int target;
		int r;
		plain_keys = '{ps2s1_pkg::CODE_ENTER, ps2s1_pkg::CODE_BACKSPACE, ps2s1_pkg::CODE_TAB,
			ps2s1_pkg::CODE_UP, ps2s1_pkg::CODE_DOWN, ps2s1_pkg::CODE_HOME,
			ps2s1_pkg::CODE_END, ps2s1_pkg::CODE_PGUP, ps2s1_pkg::CODE_PGDN};
		ext_keys = '{ps2s1_pkg::CODE_UP, ps2s1_pkg::CODE_DOWN, ps2s1_pkg::CODE_LEFT,
			ps2s1_pkg::CODE_RIGHT, ps2s1_pkg::CODE_HOME, ps2s1_pkg::CODE_END,
			ps2s1_pkg::CODE_PGUP, ps2s1_pkg::CODE_PGDN, ps2s1_pkg::CODE_DELETE};
		mods = '{ps2s1_pkg::CODE_LSHIFT, ps2s1_pkg::CODE_RSHIFT, ps2s1_pkg::CODE_CTRL,
			ps2s1_pkg::CODE_ALT};
		target = codes_sent + n_codes;
		while (codes_sent < target) begin
			r = $urandom_range(99);
			if (r < 45) begin
				send_code(ps2s1_pkg::code_t'($urandom_range(ps2s1_pkg::TABLE_LEN - 1)));
			end else if (r < 55) begin
				send_code(plain_keys[$urandom_range(8)]);
			end else if (r < 67) begin
				send_code(ps2s1_pkg::CODE_EXT_PREFIX);
				if ($urandom_range(9) == 0) send_code(ps2s1_pkg::code_t'($urandom_range(127)));
				else send_code(ext_keys[$urandom_range(8)]);
			end else if (r < 82) begin
				send_code(mods[$urandom_range(3)] | ($urandom_range(1) ? BREAK_FLAG : 8'h00));
			end else if (r < 90) begin
				send_code(ps2s1_pkg::code_t'($urandom_range(255, 128)));
			end else begin
				send_code(ps2s1_pkg::code_t'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_keys();
		test_modifiers();
		test_extended_prefix();
		hold_until_drained();
		send_idle_pct = 13;
		recv_stall_pct = 68;
		test_random_traffic(260);
		hold_until_drained();
		send_idle_pct = 68;
		recv_stall_pct = 13;
		test_random_traffic(260);
		hold_until_drained();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_traffic(260);
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_keys.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		fail_count += expected_keys.size();
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
